// ===== rtl/ubxr_pkg.sv =====
// ============================================================================
// ubxr_pkg
// Shared types and constants for the binary frame receiver.
// ============================================================================
`default_nettype none

package ubxr_pkg;

    // Frame layout constants
    localparam logic [7:0] SYNC_ONE = 8'hB5;
    localparam logic [7:0] SYNC_TWO = 8'h62;

    // Largest accepted frame, header, payload and checksum included, sync bytes excluded
    localparam int BUFFER_BYTES = 128;

    // Known id table
    localparam int TABLE_ENTRIES = 12;
    localparam int TABLE_IDX_W   = 4;

    // Byte position counter width, enough for the largest frame
    localparam int POS_W = 8;

    // Configuration port
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // Register indexes
    localparam logic [2:0] REG_ACK_ID    = 3'd0;
    localparam logic [2:0] REG_NACK_ID   = 3'd1;
    localparam logic [2:0] REG_IDS_LOW   = 3'd2;
    localparam logic [2:0] REG_IDS_MID   = 3'd3;
    localparam logic [2:0] REG_IDS_HIGH  = 3'd4;
    localparam logic [2:0] REG_KNOWN_CNT = 3'd5;

    // Register reset values
    localparam logic [15:0] ACK_ID_RESET  = 16'h0105;
    localparam logic [15:0] NACK_ID_RESET = 16'h0005;

    // Result status codes
    localparam logic [2:0] STATUS_BAD_CHECKSUM = 3'd0;
    localparam logic [2:0] STATUS_ACK          = 3'd1;
    localparam logic [2:0] STATUS_NACK         = 3'd2;
    localparam logic [2:0] STATUS_KNOWN        = 3'd3;
    localparam logic [2:0] STATUS_UNKNOWN      = 3'd4;

    // Configuration as seen by the classifier
    typedef struct packed {
        logic [15:0]                        ack_id;
        logic [15:0]                        nack_id;
        logic [TABLE_ENTRIES-1:0][15:0]     known_ids;
        logic [3:0]                         known_count;
    } cfg_t;

    // Completed frame handed from the framer to the classifier
    typedef struct packed {
        logic        checksum_ok;
        logic [15:0] frame_id;
        logic [15:0] acked_id;
        logic [6:0]  pay_len;
    } frame_rec_t;

endpackage

`default_nettype wire

// ===== rtl/ubxr_cfg_regs.sv =====
// ============================================================================
// ubxr_cfg_regs
// Configuration register file behind a simple APB-style port.
// ============================================================================
`default_nettype none

module ubxr_cfg_regs
    import ubxr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [15:0] ack_id_reg;
    logic [15:0] nack_id_reg;
    logic [63:0] ids_low_reg;
    logic [63:0] ids_mid_reg;
    logic [63:0] ids_high_reg;
    logic [3:0]  known_count_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[5:3];

    // Register writes complete in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_id_reg      <= ACK_ID_RESET;
            nack_id_reg     <= NACK_ID_RESET;
            ids_low_reg     <= '0;
            ids_mid_reg     <= '0;
            ids_high_reg    <= '0;
            known_count_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ACK_ID:    ack_id_reg      <= pwdata[15:0];
                REG_NACK_ID:   nack_id_reg     <= pwdata[15:0];
                REG_IDS_LOW:   ids_low_reg     <= pwdata;
                REG_IDS_MID:   ids_mid_reg     <= pwdata;
                REG_IDS_HIGH:  ids_high_reg    <= pwdata;
                REG_KNOWN_CNT: known_count_reg <= pwdata[3:0];
                default:       ;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_ACK_ID:    prdata = {48'd0, ack_id_reg};
            REG_NACK_ID:   prdata = {48'd0, nack_id_reg};
            REG_IDS_LOW:   prdata = ids_low_reg;
            REG_IDS_MID:   prdata = ids_mid_reg;
            REG_IDS_HIGH:  prdata = ids_high_reg;
            REG_KNOWN_CNT: prdata = {60'd0, known_count_reg};
            default:       prdata = '0;
        endcase
    end

    // Split the three table words into individual 16-bit entries.
    always_comb
    begin
        logic [63:0] word;
        cfg.ack_id      = ack_id_reg;
        cfg.nack_id     = nack_id_reg;
        cfg.known_count = known_count_reg;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            if (k < 4)
                word = ids_low_reg;
            else if (k < 8)
                word = ids_mid_reg;
            else
                word = ids_high_reg;
            cfg.known_ids[k] = word[16*(k % 4) +: 16];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ubxr_framer.sv =====
// ============================================================================
// ubxr_framer
// Byte-serial frame tracker: sync detection, header capture, running
// Fletcher sums and checksum compare. Completed frames land in a register.
// ============================================================================
`default_nettype none

module ubxr_framer
    import ubxr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            rec_valid,
    output frame_rec_t      rec,
    input  wire logic       rec_ready
);

    logic             sync_seen_reg, sync_seen_next;
    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       sum_a_reg, sum_a_next;
    logic [7:0]       sum_b_reg, sum_b_next;
    logic [15:0]      msg_id_reg, msg_id_next;
    logic [15:0]      acked_reg, acked_next;
    logic [7:0]       check_reg, check_next;
    logic             rec_valid_reg;
    frame_rec_t       rec_reg;
    frame_rec_t       rec_next;
    logic             emit;
    logic             accept;

    assign in_ready  = !rec_valid_reg || rec_ready;
    assign accept    = in_valid && in_ready;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    // Next-state logic for one received byte.
    always_comb
    begin
        logic        proceed;
        logic [16:0] data_end;
        logic [7:0]  sum_a_new;

        sync_seen_next = sync_seen_reg;
        in_frame_next  = in_frame_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        msg_id_next    = msg_id_reg;
        acked_next     = acked_reg;
        check_next     = check_reg;
        emit           = 1'b0;
        proceed        = 1'b1;
        data_end       = {1'b0, len_reg} + 17'd4;
        sum_a_new      = sum_a_reg + rx_byte;

        rec_next             = rec_reg;
        rec_next.checksum_ok = (sum_a_reg == check_reg) && (sum_b_reg == rx_byte);
        rec_next.frame_id    = msg_id_reg;
        rec_next.pay_len     = len_reg[6:0];

        // Sync pair detection; a sync pair restarts the frame at any time.
        if (rx_byte == SYNC_ONE)
        begin
            sync_seen_next = 1'b1;
        end
        else if (sync_seen_reg && rx_byte == SYNC_TWO)
        begin
            sync_seen_next = 1'b0;
            in_frame_next  = 1'b1;
            pos_next       = '0;
            len_next       = '0;
            sum_a_next     = '0;
            sum_b_next     = '0;
            msg_id_next    = '0;
            acked_next     = '0;
            check_next     = '0;
            proceed        = 1'b0;
        end
        else
        begin
            sync_seen_next = 1'b0;
        end

        if (proceed && in_frame_reg)
        begin
            // Header and first payload bytes are captured by position.
            if (pos_reg == POS_W'(0))
                msg_id_next[7:0] = rx_byte;
            else if (pos_reg == POS_W'(1))
                msg_id_next[15:8] = rx_byte;
            else if (pos_reg == POS_W'(2))
                len_next[7:0] = rx_byte;
            else if (pos_reg == POS_W'(3))
                len_next[15:8] = rx_byte;

            if (pos_reg == POS_W'(4))
                acked_next[7:0] = rx_byte;
            else if (pos_reg == POS_W'(5))
                acked_next[15:8] = rx_byte;

            pos_next = pos_reg + POS_W'(1);

            if (pos_reg < POS_W'(4) || {9'd0, pos_reg} < data_end)
            begin
                // Header or payload byte: update the running sums.
                sum_a_next = sum_a_new;
                sum_b_next = sum_b_reg + sum_a_new;
                if (pos_reg == POS_W'(3)
                    && ({1'b0, len_next} + 17'd6) > 17'(BUFFER_BYTES))
                    in_frame_next = 1'b0;
            end
            else if ({9'd0, pos_reg} == data_end)
            begin
                // First checksum byte.
                check_next = rx_byte;
            end
            else
            begin
                // Second checksum byte: the frame is complete.
                in_frame_next     = 1'b0;
                emit              = 1'b1;
                rec_next.acked_id = acked_next;
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_seen_reg <= 1'b0;
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            len_reg       <= '0;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            msg_id_reg    <= '0;
            acked_reg     <= '0;
            check_reg     <= '0;
        end
        else if (accept)
        begin
            sync_seen_reg <= sync_seen_next;
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            msg_id_reg    <= msg_id_next;
            acked_reg     <= acked_next;
            check_reg     <= check_next;
        end
    end

    // Completed frame register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            rec_valid_reg <= 1'b1;
        end
        else if (rec_ready)
        begin
            rec_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            rec_reg <= rec_next;
    end

endmodule

`default_nettype wire

// ===== rtl/ubxr_classify.sv =====
// ============================================================================
// ubxr_classify
// Classifies a completed frame: ack and nack match, known id table lookup,
// and the result register that drives the output channel.
// ============================================================================
`default_nettype none

module ubxr_classify
    import ubxr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cfg_t                    cfg,
    input  wire logic                    rec_valid,
    input  wire frame_rec_t              rec,
    output logic                         rec_ready,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [2:0]                   frame_status,
    output logic [15:0]                  frame_message_id,
    output logic [15:0]                  acked_message_id,
    output logic [6:0]                   frame_payload_length,
    output logic                         table_hit,
    output logic [TABLE_IDX_W-1:0]       table_index
);

    logic                   out_valid_reg;
    logic [2:0]             status_reg, status_next;
    logic [15:0]            msg_id_reg;
    logic [15:0]            acked_reg, acked_next;
    logic [6:0]             length_reg;
    logic                   hit_reg, hit_next;
    logic [TABLE_IDX_W-1:0] index_reg, index_next;
    logic                   take;
    logic                   is_ack;
    logic                   is_nack;
    logic [15:0]            key;
    logic [3:0]             limit;
    logic                   lookup_hit;
    logic [TABLE_IDX_W-1:0] lookup_idx;

    assign rec_ready = !out_valid_reg || out_ready;
    assign take      = rec_valid && rec_ready;

    assign is_ack  = (rec.frame_id == cfg.ack_id);
    assign is_nack = (rec.frame_id == cfg.nack_id);
    assign key     = (is_ack || is_nack) ? rec.acked_id : rec.frame_id;
    assign limit   = (cfg.known_count > 4'(TABLE_ENTRIES)) ? 4'(TABLE_ENTRIES)
                                                            : cfg.known_count;

    // Table lookup: lowest valid entry that matches the key.
    always_comb
    begin
        lookup_hit = 1'b0;
        lookup_idx = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--)
        begin
            if (4'(k) < limit && cfg.known_ids[k] == key)
            begin
                lookup_hit = 1'b1;
                lookup_idx = TABLE_IDX_W'(k);
            end
        end
    end

    // Status selection; ack wins over nack, both over the table.
    always_comb
    begin
        status_next = STATUS_BAD_CHECKSUM;
        acked_next  = '0;
        hit_next    = 1'b0;
        index_next  = '0;
        if (rec.checksum_ok)
        begin
            hit_next   = lookup_hit;
            index_next = lookup_idx;
            if (is_ack)
            begin
                status_next = STATUS_ACK;
                acked_next  = rec.acked_id;
            end
            else if (is_nack)
            begin
                status_next = STATUS_NACK;
                acked_next  = rec.acked_id;
            end
            else
            begin
                status_next = lookup_hit ? STATUS_KNOWN : STATUS_UNKNOWN;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg <= status_next;
            msg_id_reg <= rec.frame_id;
            acked_reg  <= acked_next;
            length_reg <= rec.pay_len;
            hit_reg    <= hit_next;
            index_reg  <= index_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign frame_status         = status_reg;
    assign frame_message_id     = msg_id_reg;
    assign acked_message_id     = acked_reg;
    assign frame_payload_length = length_reg;
    assign table_hit            = hit_reg;
    assign table_index          = index_reg;

endmodule

`default_nettype wire

// ===== rtl/ubx_frame_receiver.sv =====
// ============================================================================
// ubx_frame_receiver
// Binary frame receiver: byte-serial sync, Fletcher-8 check and message
// classification with a loadable table of known ids.
// ============================================================================
//
//  Channel  | Signals                                   | Transfer
//  ---------+-------------------------------------------+-------------------------
//  input    | in_valid, in_ready, rx_byte               | one received byte
//  output   | out_valid, out_ready, frame_status, ...   | one completed frame
//  config   | psel, penable, pwrite, paddr, pwdata, ... | one 64-bit register access
//
//  One byte is accepted per cycle while in_ready is high. A completed frame
//  passes through the frame register and then the result register behind
//  the table lookup before it reaches the output.
//  Reset clears the frame state and loads the register defaults.
//  A stalled output fills the result register and then the frame register;
//  only then does in_ready drop.
// ============================================================================
`default_nettype none

module ubx_frame_receiver
    import ubxr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Byte input
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            rx_byte,
    // Frame result
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [2:0]                 frame_status,
    output logic [15:0]                frame_message_id,
    output logic [15:0]                acked_message_id,
    output logic [6:0]                 frame_payload_length,
    output logic                       table_hit,
    output logic [TABLE_IDX_W-1:0]     table_index,
    // Configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t       cfg;
    logic       rec_valid;
    logic       rec_ready;
    frame_rec_t rec;

    // Configuration registers.
    ubxr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Frame tracking and checksum.
    ubxr_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_ready (rec_ready)
    );

    // Classification and result register.
    ubxr_classify u_classify (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg),
        .rec_valid            (rec_valid),
        .rec                  (rec),
        .rec_ready            (rec_ready),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .frame_status         (frame_status),
        .frame_message_id     (frame_message_id),
        .acked_message_id     (acked_message_id),
        .frame_payload_length (frame_payload_length),
        .table_hit            (table_hit),
        .table_index          (table_index)
    );

endmodule

`default_nettype wire

// ===== tb/tb_ubx_frame_receiver.sv =====
// ============================================================================
// tb_ubx_frame_receiver
// Self-checking testbench for the binary frame receiver. A directed table of
// frames runs first with the reset register values. Random frames, noise,
// truncated and oversized frames follow under several register settings.
// Every completed frame from the block is compared with an internal
// prediction of the receiver or a typed table result, and register writes are read back.
// ============================================================================
`timescale 1ns / 1ps

module tb_ubx_frame_receiver;
    import ubxr_pkg::*;

    // Expected contents of one completed frame transfer
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] frame_id;
        logic [15:0] acked_id;
        logic [6:0]  pay_len;
        logic        hit;
        logic [3:0]  index;
    } frame_res_t;

    // One directed frame: header, payload pattern, checksum damage, framing
    typedef struct packed {
        logic [7:0]  cls;
        logic [7:0]  idb;
        logic [15:0] len;
        logic [7:0]  p0;
        logic [7:0]  p1;
        logic [7:0]  fill;
        logic [7:0]  cka_x;
        logic [7:0]  ckb_x;
        logic [7:0]  cut;
        logic [7:0]  tail;
        logic        pre;
        logic        typed;
        frame_res_t  want;
    } frame_row_t;

    localparam int NUM_DIR       = 13;
    localparam int NUM_PHASES    = 5;
    localparam int PHASE_BYTES   = 120;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [2:0]            frame_status;
    logic [15:0]           frame_message_id;
    logic [15:0]           acked_message_id;
    logic [6:0]            frame_payload_length;
    logic                  table_hit;
    logic [TABLE_IDX_W-1:0] table_index;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Register copies held by the predictor
    logic [15:0] c_ack;
    logic [15:0] c_nack;
    logic [15:0] c_ids [TABLE_ENTRIES];
    logic [3:0]  c_count;

    // Receiver state held by the predictor
    logic        p_sync;
    logic        p_in_frame;
    logic [15:0] p_pos;
    logic [15:0] p_len;
    logic [7:0]  p_sum_a;
    logic [7:0]  p_sum_b;
    logic [15:0] p_msg;
    logic [15:0] p_acked;
    logic [7:0]  p_ck_lo;

    frame_res_t  expected_frames [$];
    logic [7:0]  tx_q [$];
    frame_row_t  dir_rows [NUM_DIR];

    // A typed expectation replaces the predicted one for the next result
    bit          typed_pending;
    frame_res_t  typed_want;

    bit          no_idle;
    int          mismatches;
    int          bytes_sent;
    int          frames_checked;
    int          status_seen [5];
    int          stall_cycles;

    ubx_frame_receiver i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .rx_byte              (rx_byte),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .frame_status         (frame_status),
        .frame_message_id     (frame_message_id),
        .acked_message_id     (acked_message_id),
        .frame_payload_length (frame_payload_length),
        .table_hit            (table_hit),
        .table_index          (table_index),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    // Clock, 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Known id table search: lowest valid entry equal to the id
    function automatic bit lookup_known(input logic [15:0] id, output logic [3:0] idx);
        int lim;
        lim = (c_count > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(c_count);
        idx = '0;
        for (int k = 0; k < lim; k++)
        begin
            if (c_ids[k] == id)
            begin
                idx = 4'(k);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advance the predicted receiver by one accepted byte
    task automatic predict_byte(input logic [7:0] b, output bit got, output frame_res_t r);
        int unsigned p;
        int unsigned len;
        logic [3:0]  idx;
        bit          hit;
        got = 1'b0;
        r   = '0;
        if (b == SYNC_ONE)
        begin
            p_sync = 1'b1;
        end
        else
        begin
            if (p_sync && b == SYNC_TWO)
            begin
                p_sync     = 1'b0;
                p_in_frame = 1'b1;
                p_pos      = '0;
                p_len      = '0;
                p_sum_a    = '0;
                p_sum_b    = '0;
                p_msg      = '0;
                p_acked    = '0;
                p_ck_lo    = '0;
                return;
            end
            p_sync = 1'b0;
        end
        if (!p_in_frame)
            return;

        p   = p_pos;
        len = p_len;
        if (p == 0)
            p_msg[7:0] = b;
        else if (p == 1)
            p_msg[15:8] = b;
        else if (p == 2)
            p_len[7:0] = b;
        else if (p == 3)
            p_len[15:8] = b;
        if (p == 4)
            p_acked[7:0] = b;
        else if (p == 5)
            p_acked[15:8] = b;

        // Header and payload bytes feed the running sums
        if (p < 4 || p < len + 4)
        begin
            p_sum_a = p_sum_a + b;
            p_sum_b = p_sum_b + p_sum_a;
            p_pos   = 16'(p + 1);
            if (p == 3 && 32'(p_len) + 6 > BUFFER_BYTES)
                p_in_frame = 1'b0;
            return;
        end
        if (p == len + 4)
        begin
            p_ck_lo = b;
            p_pos   = 16'(p + 1);
            return;
        end

        // Second checksum byte closes the frame
        p_in_frame = 1'b0;
        p_pos      = 16'(p + 1);
        hit        = 1'b0;
        idx        = '0;
        r.frame_id = p_msg;
        r.pay_len  = p_len[6:0];
        if (p_sum_a != p_ck_lo || p_sum_b != b)
        begin
            r.status = STATUS_BAD_CHECKSUM;
        end
        else if (p_msg == c_ack)
        begin
            r.status   = STATUS_ACK;
            r.acked_id = p_acked;
            hit        = lookup_known(p_acked, idx);
        end
        else if (p_msg == c_nack)
        begin
            r.status   = STATUS_NACK;
            r.acked_id = p_acked;
            hit        = lookup_known(p_acked, idx);
        end
        else
        begin
            hit      = lookup_known(p_msg, idx);
            r.status = hit ? STATUS_KNOWN : STATUS_UNKNOWN;
        end
        r.hit   = hit;
        r.index = idx;
        got     = 1'b1;
    endtask

    // Append one frame, optionally damaged, truncated or padded, to the byte queue
    task automatic build_frame(input logic [7:0] cls, input logic [7:0] idb,
                               input logic [15:0] len, input logic [7:0] p0,
                               input logic [7:0] p1, input logic [7:0] fill,
                               input logic [7:0] cka_x, input logic [7:0] ckb_x,
                               input logic [7:0] cut, input logic [7:0] tail,
                               input bit pre, input bit rnd);
        logic [7:0] fq [$];
        logic [7:0] ca;
        logic [7:0] cb;
        logic [7:0] v;
        int         n;
        fq = {};
        ca = '0;
        cb = '0;
        n  = (32'(len) + 6 > BUFFER_BYTES) ? 8 : int'(len);
        if (pre)
        begin
            tx_q.push_back(SYNC_TWO);
            tx_q.push_back(SYNC_ONE);
        end
        fq.push_back(SYNC_ONE);
        fq.push_back(SYNC_TWO);
        fq.push_back(cls);
        fq.push_back(idb);
        fq.push_back(len[7:0]);
        fq.push_back(len[15:8]);
        for (int k = 0; k < n; k++)
        begin
            v = (k == 0) ? p0 : (k == 1) ? p1 : (rnd ? 8'($urandom_range(0, 255)) : fill);
            fq.push_back(v);
        end
        for (int k = 2; k < fq.size(); k++)
        begin
            ca = ca + fq[k];
            cb = cb + ca;
        end
        fq.push_back(ca ^ cka_x);
        fq.push_back(cb ^ ckb_x);
        if (cut != 0)
        begin
            while (fq.size() > cut)
                void'(fq.pop_back());
        end
        foreach (fq[k])
            tx_q.push_back(fq[k]);
        for (int k = 0; k < tail; k++)
            tx_q.push_back(rnd ? 8'($urandom_range(0, 255)) : fill);
    endtask

    // Random item: mostly well-formed frames, some noise, damage and truncation
    task automatic rand_item();
        int          r;
        int          ri;
        int          m;
        logic [15:0] msg;
        logic [15:0] len;
        logic [15:0] arg;
        logic [7:0]  cka;
        logic [7:0]  ckb;
        logic [7:0]  cut;
        logic [7:0]  tail;
        bit          pre;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            m = $urandom_range(1, 6);
            repeat (m)
            begin
                ri = $urandom_range(0, 9);
                tx_q.push_back(ri < 3 ? SYNC_ONE : ri == 3 ? SYNC_TWO :
                               8'($urandom_range(0, 255)));
            end
            return;
        end

        // Message id: acknowledge, not-acknowledge, table entry or anything
        ri = $urandom_range(0, 99);
        if (ri < 25)
            msg = c_ack;
        else if (ri < 45)
            msg = c_nack;
        else if (ri < 70)
            msg = c_ids[$urandom_range(0, TABLE_ENTRIES - 1)];
        else
            msg = 16'($urandom_range(0, 65535));

        arg = ($urandom_range(0, 1) == 1) ? c_ids[$urandom_range(0, TABLE_ENTRIES - 1)]
                                          : 16'($urandom_range(0, 65535));

        // Mostly short payloads, a few at the buffer limit or beyond it
        ri = $urandom_range(0, 99);
        if (ri < 65)
            len = 16'($urandom_range(0, 8));
        else if (ri < 82)
            len = 16'($urandom_range(9, 40));
        else if (ri < 92)
            len = 16'($urandom_range(100, 122));
        else if (ri < 95)
            len = 16'(BUFFER_BYTES - 6);
        else if (ri < 98)
            len = 16'($urandom_range(BUFFER_BYTES - 5, 200));
        else
            len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};

        cka = '0;
        ckb = '0;
        if ($urandom_range(0, 99) < 10)
        begin
            m = $urandom_range(1, 3);
            if (m[0])
                cka = 8'($urandom_range(1, 255));
            if (m[1])
                ckb = 8'($urandom_range(1, 255));
        end
        cut  = ($urandom_range(0, 99) < 6) ? 8'($urandom_range(1, 20)) : 8'd0;
        tail = ($urandom_range(0, 99) < 15) ? 8'($urandom_range(1, 4)) : 8'd0;
        pre  = ($urandom_range(0, 99) < 10);
        build_frame(msg[7:0], msg[15:8], len, arg[7:0], arg[15:8], 8'h00,
                    cka, ckb, cut, tail, pre, 1'b1);
    endtask

    // Send one byte with random idle cycles ahead of it, then predict
    task automatic send_byte(input logic [7:0] b);
        bit         got;
        frame_res_t r;
        while (!no_idle && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        predict_byte(b, got, r);
        if (got)
        begin
            if (typed_pending)
            begin
                expected_frames.push_back(typed_want);
                typed_pending = 1'b0;
            end
            else
            begin
                expected_frames.push_back(r);
            end
        end
        @(negedge clk);
    endtask

    task automatic send_queue();
        while (tx_q.size() != 0)
            send_byte(tx_q.pop_front());
    endtask

    // Stop sending and let every expected frame and the pipeline drain
    task automatic go_quiet();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Register write followed by a read back; the predictor copy follows the write
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        logic [63:0] kept;
        logic [63:0] seen;
        case (idx)
            REG_ACK_ID:    kept = {48'd0, value[15:0]};
            REG_NACK_ID:   kept = {48'd0, value[15:0]};
            REG_KNOWN_CNT: kept = {60'd0, value[3:0]};
            default:       kept = value;
        endcase
        case (idx)
            REG_ACK_ID:    c_ack   = kept[15:0];
            REG_NACK_ID:   c_nack  = kept[15:0];
            REG_IDS_LOW:   for (int k = 0; k < 4; k++) c_ids[k]     = kept[16*k +: 16];
            REG_IDS_MID:   for (int k = 0; k < 4; k++) c_ids[4 + k] = kept[16*k +: 16];
            REG_IDS_HIGH:  for (int k = 0; k < 4; k++) c_ids[8 + k] = kept[16*k +: 16];
            REG_KNOWN_CNT: c_count = kept[3:0];
            default:       ;
        endcase

        // Write: setup then access
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);

        // Read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        seen = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== kept)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Register %0d read back: expected %h, got %h", idx, kept, seen);
        end
        // The port goes idle before the next access
        @(negedge clk);
    endtask

    task automatic set_registers(input logic [15:0] ack, input logic [15:0] nack,
                                 input logic [63:0] low, input logic [63:0] mid,
                                 input logic [63:0] high, input logic [3:0] count);
        cfg_write(REG_ACK_ID, {16'($urandom_range(0, 65535)), 32'd0, ack});
        cfg_write(REG_NACK_ID, {16'($urandom_range(0, 65535)), 32'd0, nack});
        cfg_write(REG_IDS_LOW, low);
        cfg_write(REG_IDS_MID, mid);
        cfg_write(REG_IDS_HIGH, high);
        cfg_write(REG_KNOWN_CNT, {28'($urandom), 32'd0, count});
    endtask

    // Output side: random back pressure
    always @(negedge clk)
        out_ready <= no_idle || ($urandom_range(0, 99) >= 9);

    // Result check: each completed frame against the oldest expectation
    always @(posedge clk)
    begin : result_check
        frame_res_t seen;
        frame_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {frame_status, frame_message_id, acked_message_id,
                    frame_payload_length, table_hit, table_index};
            if (seen.status <= STATUS_UNKNOWN)
                status_seen[seen.status]++;
            frames_checked++;
            if (expected_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected frame: st %0d id %h ack %h len %0d hit %0d idx %0d",
                             seen.status, seen.frame_id, seen.acked_id, seen.pay_len,
                             seen.hit, seen.index);
            end
            else
            begin
                want = expected_frames.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch want st %0d id %h ack %h len %0d hit %0d idx %0d",
                                 want.status, want.frame_id, want.acked_id,
                                 want.pay_len, want.hit, want.index);
                        $display("Mismatch got  st %0d id %h ack %h len %0d hit %0d idx %0d",
                                 seen.status, seen.frame_id, seen.acked_id,
                                 seen.pay_len, seen.hit, seen.index);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("ubx_frame_receiver regression: fail");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = '0;
        out_ready     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        no_idle       = 1'b0;
        typed_pending = 1'b0;
        typed_want    = '0;
        mismatches    = 0;
        bytes_sent    = 0;
        frames_checked = 0;
        stall_cycles  = 0;
        foreach (status_seen[k])
            status_seen[k] = 0;

        // Predictor starts from the reset state
        c_ack   = ACK_ID_RESET;
        c_nack  = NACK_ID_RESET;
        c_count = '0;
        foreach (c_ids[k])
            c_ids[k] = '0;
        p_sync     = 1'b0;
        p_in_frame = 1'b0;
        p_pos      = '0;
        p_len      = '0;
        p_sum_a    = '0;
        p_sum_b    = '0;
        p_msg      = '0;
        p_acked    = '0;
        p_ck_lo    = '0;

        // Directed frames under the reset registers:
        // cls, id, len, p0, p1, fill, ck_a flip, ck_b flip, cut, tail, pre, typed, result
        dir_rows[0]  = {8'h05, 8'h01, 16'd2, 8'h06, 8'h01, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0,
                        1'b0, 1'b1, {STATUS_ACK, 16'h0105, 16'h0106, 7'd2, 1'b0, 4'd0}};
        dir_rows[1]  = {8'h05, 8'h00, 16'd2, 8'h13, 8'h02, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0,
                        1'b0, 1'b1, {STATUS_NACK, 16'h0005, 16'h0213, 7'd2, 1'b0, 4'd0}};
        dir_rows[2]  = {8'h01, 8'h07, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0,
                        1'b0, 1'b1, {STATUS_UNKNOWN, 16'h0701, 16'h0000, 7'd0, 1'b0, 4'd0}};
        dir_rows[3]  = {8'h0A, 8'h04, 16'd3, 8'hAA, 8'hAA, 8'hAA, 8'h01, 8'h00, 8'd0, 8'd0,
                        1'b0, 1'b1, {STATUS_BAD_CHECKSUM, 16'h040A, 16'h0000, 7'd3, 1'b0, 4'd0}};
        // Acknowledge with an empty payload: the acked id picks up checksum bytes
        dir_rows[4]  = {8'h05, 8'h01, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0,
                        1'b0, 1'b0, 47'd0};
        dir_rows[5]  = {8'h05, 8'h00, 16'd1, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0,
                        1'b0, 1'b0, 47'd0};
        // Largest frame that fits, all ones
        dir_rows[6]  = {8'hFF, 8'hFF, 16'd122, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'd0, 8'd0,
                        1'b0, 1'b0, 47'd0};
        // Oversized by one byte, then by the high length byte
        dir_rows[7]  = {8'h10, 8'h20, 16'd123, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0,
                        1'b0, 1'b0, 47'd0};
        dir_rows[8]  = {8'h06, 8'h06, 16'h0100, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0,
                        1'b0, 1'b0, 47'd0};
        // First sync byte as ordinary payload data
        dir_rows[9]  = {8'h00, 8'h00, 16'd4, 8'hB5, 8'h00, 8'h7F, 8'h00, 8'h00, 8'd0, 8'd0,
                        1'b0, 1'b0, 47'd0};
        // Truncated frame, the next sync restarts mid-frame
        dir_rows[10] = {8'h03, 8'h03, 16'd6, 8'h55, 8'h55, 8'h55, 8'h00, 8'h00, 8'd7, 8'd0,
                        1'b0, 1'b0, 47'd0};
        // Full sync pair inside the payload
        dir_rows[11] = {8'h01, 8'h02, 16'd6, 8'hB5, 8'h62, 8'h11, 8'h00, 8'h00, 8'd0, 8'd0,
                        1'b0, 1'b0, 47'd0};
        // Stray bytes and a doubled sync ahead, ignored bytes after completion
        dir_rows[12] = {8'h02, 8'h15, 16'd5, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'd0, 8'd3,
                        1'b1, 1'b0, 47'd0};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIR; i++)
        begin
            typed_pending = dir_rows[i].typed;
            typed_want    = dir_rows[i].want;
            build_frame(dir_rows[i].cls, dir_rows[i].idb, dir_rows[i].len, dir_rows[i].p0,
                        dir_rows[i].p1, dir_rows[i].fill, dir_rows[i].cka_x,
                        dir_rows[i].ckb_x, dir_rows[i].cut, dir_rows[i].tail,
                        dir_rows[i].pre, 1'b0);
            send_queue();
            typed_pending = 1'b0;
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin : phase_loop
            int          start;
            logic [15:0] same;
            logic [63:0] words;
            go_quiet();
            words = {$urandom, $urandom};
            same  = 16'($urandom_range(0, 65535));
            case (ph)
                0: set_registers(ACK_ID_RESET, NACK_ID_RESET, {$urandom, $urandom},
                                 {$urandom, $urandom}, {$urandom, $urandom}, 4'd12);
                1: set_registers(16'h0000, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0,
                                 {$urandom, $urandom}, 4'd15);
                2: set_registers(16'hFFFF, 16'h0000, {$urandom, $urandom},
                                 {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
                3: set_registers(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                 words, words, {words[15:0], words[47:0]},
                                 4'($urandom_range(1, 11)));
                default: set_registers(same, same, {$urandom, $urandom},
                                       {$urandom, $urandom}, {$urandom, $urandom}, 4'd1);
            endcase
            no_idle = (ph == 1);
            start   = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
            begin
                rand_item();
                send_queue();
            end
            no_idle = 1'b0;
        end

        go_quiet();
        $display("Sent %0d bytes over the reset setting and %0d register settings; %0d frames",
                 bytes_sent, NUM_PHASES, frames_checked);
        $display("checked: bad %0d, ack %0d, nack %0d, known %0d, unknown %0d; mismatches %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], mismatches);
        if (mismatches == 0 && expected_frames.size() == 0)
            $display("ubx_frame_receiver regression: pass");
        else
            $display("ubx_frame_receiver regression: fail");
        $finish;
    end

endmodule
